// ===== rtl/sipq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sipq_pkg
// Shared constants and types for the sorted-insert priority queue.
// ----------------------------------------------------------------------------
package sipq_pkg;

    // default sizes
    localparam int DEPTH_DEF     = 8;
    localparam int PRIO_BITS_DEF = 16;
    localparam int TAG_BITS_DEF  = 16;

    // configuration port
    localparam int CAP_BITS       = 4;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 4;

    localparam logic [CFG_INDEX_BITS-1:0] REG_CAPACITY   = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ORDER_MODE = 1'b1;

    localparam logic [CAP_BITS-1:0] CAPACITY_RESET = 4'd8;

    localparam logic ORDER_ASCEND  = 1'b0;
    localparam logic ORDER_DESCEND = 1'b1;

    // operation kinds
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_FULL      = 2'd1;
    localparam logic [1:0] ERR_POP_EMPTY = 2'd2;

    // broadcast control to every cell
    typedef struct packed {
        logic push_en;     // insert the new entry this cycle
        logic pop_en;      // shift every cell toward the front
        logic order_desc;  // largest priority first
    } cell_ctrl_t;

endpackage

// ===== rtl/sipq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sipq_cell
// One slot of the sorted queue: holds an entry, tests the new key against it
// and takes its left neighbor, the new entry or its right neighbor.
// ----------------------------------------------------------------------------
module sipq_cell #(
    parameter int PRIO_BITS = sipq_pkg::PRIO_BITS_DEF,
    parameter int TAG_BITS  = sipq_pkg::TAG_BITS_DEF
) (
    input  logic                   clk,
    input  sipq_pkg::cell_ctrl_t   ctrl,
    input  logic                   entry_valid,
    input  logic [PRIO_BITS-1:0]   new_prio,
    input  logic [TAG_BITS-1:0]    new_tag,
    input  logic [PRIO_BITS-1:0]   left_prio,
    input  logic [TAG_BITS-1:0]    left_tag,
    input  logic [PRIO_BITS-1:0]   right_prio,
    input  logic [TAG_BITS-1:0]    right_tag,
    input  logic                   found_in,
    output logic [PRIO_BITS-1:0]   prio,
    output logic [TAG_BITS-1:0]    tag,
    output logic                   found_out,
    output logic                   hit
);
    import sipq_pkg::*;

    logic [PRIO_BITS-1:0] prio_reg;
    logic [TAG_BITS-1:0]  tag_reg;
    logic                 goes_before;
    logic                 take;

    always_comb
    begin
        goes_before = (ctrl.order_desc == ORDER_DESCEND) ? !(new_prio < prio_reg)
                                                         : (new_prio < prio_reg);
        hit       = entry_valid & goes_before;
        // first empty slot also takes the entry (append)
        take      = !entry_valid | goes_before;
        found_out = found_in | take;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push_en)
        begin
            if (found_in)
            begin
                prio_reg <= left_prio;
                tag_reg  <= left_tag;
            end
            else if (take)
            begin
                prio_reg <= new_prio;
                tag_reg  <= new_tag;
            end
        end
        else if (ctrl.pop_en)
        begin
            prio_reg <= right_prio;
            tag_reg  <= right_tag;
        end
    end

    assign prio = prio_reg;
    assign tag  = tag_reg;

endmodule

// ===== rtl/sorted_insert_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue
// Bounded priority queue held sorted in a row of shifting cells.
// ----------------------------------------------------------------------------
// Takes one push or pop per clock while not stalled; the result for an item is
// valid in the cycle after its transfer and the next item may transfer in that
// same cycle while the result is taken. The speed is set by the cell row: every
// cell compares the new key in parallel and a found flag ripples through the row
// to pick the insert slot, so the row length (DEPTH) sets the critical path.
// Results show the queue after the operation; a push beyond the effective
// capacity (capacity 0 acts as 1, above DEPTH acts as DEPTH) or a pop on an
// empty queue reports an error code and leaves the queue unchanged.
// Write configuration only while no result is pending; the block does not enforce it.
module sorted_insert_priority_queue #(
    parameter int DEPTH     = sipq_pkg::DEPTH_DEF,
    parameter int PRIO_BITS = sipq_pkg::PRIO_BITS_DEF,
    parameter int TAG_BITS  = sipq_pkg::TAG_BITS_DEF,
    parameter int CNT_BITS  = $clog2(DEPTH + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_we,
    input  logic [sipq_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [sipq_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                kind,
    input  logic [PRIO_BITS-1:0]                item_priority,
    input  logic [TAG_BITS-1:0]                 item_tag,
    // output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [PRIO_BITS-1:0]                front_priority,
    output logic [TAG_BITS-1:0]                 front_tag,
    output logic [PRIO_BITS-1:0]                back_priority,
    output logic [TAG_BITS-1:0]                 back_tag,
    output logic [CNT_BITS-1:0]                 entry_count,
    output logic                                is_empty,
    output logic                                is_full,
    output logic [1:0]                          op_error
);
    import sipq_pkg::*;

    localparam int CMP_BITS = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;

    logic [CAP_BITS-1:0]  capacity_reg;
    logic                 order_mode_reg;
    logic [CNT_BITS-1:0]  count_reg;
    logic [CNT_BITS-1:0]  count_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [1:0]           err_reg;
    logic [1:0]           err_next;
    logic                 full_reg;
    logic                 full_next;
    logic [PRIO_BITS-1:0] back_prio_reg;
    logic [PRIO_BITS-1:0] back_prio_next;
    logic [TAG_BITS-1:0]  back_tag_reg;
    logic [TAG_BITS-1:0]  back_tag_next;

    logic                 in_xfer;
    logic [CMP_BITS-1:0]  cap_eff;
    logic                 full_now;
    logic                 empty_now;
    logic                 do_push;
    logic                 do_pop;
    logic                 append;
    cell_ctrl_t           ctrl;

    logic [PRIO_BITS-1:0] cell_prio [DEPTH];
    logic [TAG_BITS-1:0]  cell_tag  [DEPTH];
    logic [DEPTH:0]       found;
    logic [DEPTH-1:0]     hit;
    logic [DEPTH-1:0]     entry_valid;

    assign in_stall = out_valid_reg & out_stall;
    assign in_xfer  = in_valid & ~in_stall;

    always_comb
    begin
        if (CMP_BITS'(capacity_reg) == '0)
            cap_eff = CMP_BITS'(1);
        else if (CMP_BITS'(capacity_reg) > CMP_BITS'(DEPTH))
            cap_eff = CMP_BITS'(DEPTH);
        else
            cap_eff = CMP_BITS'(capacity_reg);
    end

    assign full_now  = CMP_BITS'(count_reg) >= cap_eff;
    assign empty_now = (count_reg == '0);
    assign do_push   = in_xfer && (kind == KIND_PUSH) && !full_now;
    assign do_pop    = in_xfer && (kind == KIND_POP) && !empty_now;

    assign ctrl.push_en    = do_push;
    assign ctrl.pop_en     = do_pop;
    assign ctrl.order_desc = order_mode_reg;

    // ---------------------------------------------------------------- cells
    assign found[0] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [PRIO_BITS-1:0] lp;
        logic [TAG_BITS-1:0]  lt;
        logic [PRIO_BITS-1:0] rp;
        logic [TAG_BITS-1:0]  rt;

        assign entry_valid[i] = CNT_BITS'(i) < count_reg;

        if (i == 0)
        begin : g_first
            assign lp = item_priority;
            assign lt = item_tag;
        end
        else
        begin : g_mid_l
            assign lp = cell_prio[i-1];
            assign lt = cell_tag[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign rp = cell_prio[i];
            assign rt = cell_tag[i];
        end
        else
        begin : g_mid_r
            assign rp = cell_prio[i+1];
            assign rt = cell_tag[i+1];
        end

        sipq_cell #(
            .PRIO_BITS (PRIO_BITS),
            .TAG_BITS  (TAG_BITS)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .entry_valid (entry_valid[i]),
            .new_prio    (item_priority),
            .new_tag     (item_tag),
            .left_prio   (lp),
            .left_tag    (lt),
            .right_prio  (rp),
            .right_tag   (rt),
            .found_in    (found[i]),
            .prio        (cell_prio[i]),
            .tag         (cell_tag[i]),
            .found_out   (found[i+1]),
            .hit         (hit[i])
        );
    end

    // no stored entry goes behind the new one: it lands at the back
    assign append = ~|hit;

    // ---------------------------------------------------------- next state
    always_comb
    begin
        count_next = count_reg;
        if (do_push)
            count_next = count_reg + CNT_BITS'(1);
        else if (do_pop)
            count_next = count_reg - CNT_BITS'(1);

        err_next = ERR_NONE;
        if (in_xfer && (kind == KIND_PUSH) && full_now)
            err_next = ERR_FULL;
        else if (in_xfer && (kind == KIND_POP) && empty_now)
            err_next = ERR_POP_EMPTY;

        full_next = CMP_BITS'(count_next) >= cap_eff;

        // the old back entry only moves, so the back changes on append alone
        back_prio_next = back_prio_reg;
        back_tag_next  = back_tag_reg;
        if (do_push && append)
        begin
            back_prio_next = item_priority;
            back_tag_next  = item_tag;
        end

        if (in_xfer)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg   <= CAPACITY_RESET;
            order_mode_reg <= ORDER_ASCEND;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_CAPACITY:   capacity_reg   <= cfg_wdata[CAP_BITS-1:0];
                    REG_ORDER_MODE: order_mode_reg <= cfg_wdata[0];
                    default:        ;
                endcase
            end
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            err_reg  <= err_next;
            full_reg <= full_next;
        end
        back_prio_reg <= back_prio_next;
        back_tag_reg  <= back_tag_next;
    end

    // -------------------------------------------------------------- outputs
    assign out_valid      = out_valid_reg;
    assign front_priority = empty_now ? '0 : cell_prio[0];
    assign front_tag      = empty_now ? '0 : cell_tag[0];
    assign back_priority  = empty_now ? '0 : back_prio_reg;
    assign back_tag       = empty_now ? '0 : back_tag_reg;
    assign entry_count    = count_reg;
    assign is_empty       = empty_now;
    assign is_full        = full_reg;
    assign op_error       = err_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_BITS'(DEPTH) >= count_reg)
        else $error("entry count above depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && (kind == KIND_PUSH) && !full_now
        |=> count_reg == $past(count_reg) + CNT_BITS'(1))
        else $error("accepted push did not add an entry");

    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && (kind == KIND_POP) && !empty_now
        |=> count_reg == $past(count_reg) - CNT_BITS'(1))
        else $error("accepted pop did not remove an entry");

    a_pop_empty_err: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && (kind == KIND_POP) && empty_now
        |=> out_valid && op_error == ERR_POP_EMPTY && count_reg == '0)
        else $error("pop on empty queue not flagged");

    a_refused_push: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && (kind == KIND_PUSH) && full_now
        |=> op_error == ERR_FULL && $stable(count_reg))
        else $error("refused push changed the queue");
`endif

endmodule
